@@ src/kbc_pkg.sv @@
`timescale 1ns / 1ps

package kbc_pkg;

   localparam int BUFFER_SIZE_DEFAULT  = 16;
   localparam int KEY_MAP_SIZE_DEFAULT = 256;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [1:0] OPERATION_KEY_DOWN = 2'd0;
   localparam logic [1:0] OPERATION_KEY_UP   = 2'd1;
   localparam logic [1:0] OPERATION_COMMAND  = 2'd2;

   localparam logic [15:0] CMD_CLEAR   = 16'd0;
   localparam logic [15:0] CMD_POP     = 16'd1;
   localparam logic [15:0] CMD_QUERY   = 16'd2;
   localparam logic [15:0] CMD_SET_MSG = 16'd3;

   localparam logic [2:0] KIND_NOP      = 3'd0;
   localparam logic [2:0] KIND_KEY_DOWN = 3'd1;
   localparam logic [2:0] KIND_KEY_UP   = 3'd2;
   localparam logic [2:0] KIND_KEY_BARE = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;
   localparam logic [2:0] KIND_POP      = 3'd5;
   localparam logic [2:0] KIND_QUERY    = 3'd6;
   localparam logic [2:0] KIND_SET_MSG  = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  code;
      logic [15:0] arg;
   } action_type;

   typedef struct packed {
      logic        c_valid;
      logic [7:0]  c_value;
      logic        irq_raise;
      logic [15:0] irq_value;
   } result_type;

endpackage

@@ src/kbc_front.sv @@
`timescale 1ns / 1ps

module kbc_front (
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_operation,
   input  logic                req_has_code,
   input  logic [7:0]          req_key_code,
   input  logic [15:0]         req_command_a,
   input  logic [15:0]         req_operand_b,
   output logic                q_push,
   input  logic                q_full,
   output kbc_pkg::action_type q_word
);

   logic [2:0] kind;

   always_comb begin
      kind = kbc_pkg::KIND_NOP;
      case (req_operation)
         kbc_pkg::OPERATION_KEY_DOWN: begin
            kind = req_has_code ? kbc_pkg::KIND_KEY_DOWN : kbc_pkg::KIND_KEY_BARE;
         end
         kbc_pkg::OPERATION_KEY_UP: begin
            kind = req_has_code ? kbc_pkg::KIND_KEY_UP : kbc_pkg::KIND_KEY_BARE;
         end
         kbc_pkg::OPERATION_COMMAND: begin
            case (req_command_a)
               kbc_pkg::CMD_CLEAR:   kind = kbc_pkg::KIND_CLEAR;
               kbc_pkg::CMD_POP:     kind = kbc_pkg::KIND_POP;
               kbc_pkg::CMD_QUERY:   kind = kbc_pkg::KIND_QUERY;
               kbc_pkg::CMD_SET_MSG: kind = kbc_pkg::KIND_SET_MSG;
               default:              kind = kbc_pkg::KIND_NOP;
            endcase
         end
         default: kind = kbc_pkg::KIND_NOP;
      endcase
   end

   assign q_word.kind = kind;
   assign q_word.code = req_key_code;
   assign q_word.arg  = req_operand_b;
   assign q_push      = req_push && !q_full;
   assign req_full    = q_full;

endmodule

@@ src/kbc_queue.sv @@
`timescale 1ns / 1ps

module kbc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kbc_pkg::action_type push_word,
   output logic                full,
   input  logic                pop,
   output kbc_pkg::action_type pop_word,
   output logic                empty
);

   localparam int PTR_W = $clog2(kbc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(kbc_pkg::QUEUE_DEPTH + 1);

   kbc_pkg::action_type slot_ff [kbc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push_ok, pop_ok;

   assign full    = count_ff == CNT_W'(kbc_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   assign pop_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(kbc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(kbc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ src/kbc_back.sv @@
`timescale 1ns / 1ps

module kbc_back #(
   parameter int BUFFER_SIZE  = kbc_pkg::BUFFER_SIZE_DEFAULT,
   parameter int KEY_MAP_SIZE = kbc_pkg::KEY_MAP_SIZE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  kbc_pkg::action_type q_word,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output kbc_pkg::result_type rsp_word
);

   localparam int IDX_W = $clog2(BUFFER_SIZE);
   localparam int MAP_W = $clog2(KEY_MAP_SIZE);

   localparam logic ST_RUN = 1'b0;
   localparam logic ST_POP = 1'b1;

   logic [7:0]              key_fifo_mem [BUFFER_SIZE];
   logic [7:0]              rd_data_ff;
   logic                    state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        count_ff, count_in;
   logic [KEY_MAP_SIZE-1:0] pressed_ff, pressed_in;
   logic                    irq_enable_ff, irq_enable_in;
   logic [15:0]             irq_message_ff, irq_message_in;
   logic                    out_valid_ff, out_valid_in;
   kbc_pkg::result_type     out_res_ff, out_res_in;

   logic                    out_space, take, load;
   logic                    fifo_we;
   logic [IDX_W:0]          slot_sum;
   logic [IDX_W-1:0]        slot;
   logic                    code_in_map, query_in_map;
   logic [MAP_W-1:0]        code_idx, query_idx;
   logic [IDX_W-1:0]        head_next;
   kbc_pkg::result_type     irq_res;

   assign out_space = !out_valid_ff || rsp_pop;
   assign take      = (state_ff == ST_RUN) && !q_empty && out_space;
   assign q_pop     = take;

   assign slot_sum  = {1'b0, head_ff} + {1'b0, count_ff};
   assign slot      = (slot_sum >= (IDX_W+1)'(BUFFER_SIZE))
                      ? IDX_W'(slot_sum - (IDX_W+1)'(BUFFER_SIZE)) : IDX_W'(slot_sum);
   assign head_next = (head_ff == IDX_W'(BUFFER_SIZE - 1)) ? '0 : head_ff + IDX_W'(1);

   assign code_in_map  = {1'b0, q_word.code} < 9'(KEY_MAP_SIZE);
   assign query_in_map = {1'b0, q_word.arg} < 17'(KEY_MAP_SIZE);
   assign code_idx     = q_word.code[MAP_W-1:0];
   assign query_idx    = q_word.arg[MAP_W-1:0];

   always_comb begin
      irq_res           = '0;
      irq_res.irq_raise = irq_enable_ff;
      irq_res.irq_value = irq_enable_ff ? irq_message_ff : 16'd0;
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      pressed_in     = pressed_ff;
      irq_enable_in  = irq_enable_ff;
      irq_message_in = irq_message_ff;
      out_res_in     = out_res_ff;
      load           = 1'b0;
      fifo_we        = 1'b0;
      if (state_ff == ST_POP) begin
         load       = 1'b1;
         out_res_in = '0;
         out_res_in.c_valid = 1'b1;
         out_res_in.c_value = rd_data_ff;
         state_in   = ST_RUN;
      end else if (take) begin
         load       = 1'b1;
         out_res_in = '0;
         case (q_word.kind)
            kbc_pkg::KIND_KEY_DOWN: begin
               out_res_in = irq_res;
               if (count_ff < IDX_W'(BUFFER_SIZE - 1)) begin
                  fifo_we  = 1'b1;
                  count_in = count_ff + IDX_W'(1);
               end
               if (code_in_map) begin
                  pressed_in[code_idx] = 1'b1;
               end
            end
            kbc_pkg::KIND_KEY_UP: begin
               out_res_in = irq_res;
               if (code_in_map) begin
                  pressed_in[code_idx] = 1'b0;
               end
            end
            kbc_pkg::KIND_KEY_BARE: begin
               out_res_in = irq_res;
            end
            kbc_pkg::KIND_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            kbc_pkg::KIND_POP: begin
               out_res_in.c_valid = 1'b1;
               if (count_ff != '0) begin
                  load     = 1'b0;
                  head_in  = head_next;
                  count_in = count_ff - IDX_W'(1);
                  state_in = ST_POP;
               end
            end
            kbc_pkg::KIND_QUERY: begin
               out_res_in.c_valid = 1'b1;
               out_res_in.c_value = {7'd0, query_in_map && pressed_ff[query_idx]};
            end
            kbc_pkg::KIND_SET_MSG: begin
               irq_message_in = q_word.arg;
               irq_enable_in  = q_word.arg != 16'd0;
            end
            default: begin
               out_res_in = '0;
            end
         endcase
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         head_ff        <= '0;
         count_ff       <= '0;
         pressed_ff     <= '0;
         irq_enable_ff  <= 1'b0;
         irq_message_ff <= 16'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         pressed_ff     <= pressed_in;
         irq_enable_ff  <= irq_enable_in;
         irq_message_ff <= irq_message_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         key_fifo_mem[slot] <= q_word.code;
      end
      rd_data_ff <= key_fifo_mem[head_ff];
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_res_ff;

   // the key buffer always keeps one slot spare
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(BUFFER_SIZE - 1))
      else $error("key count beyond buffer limit");

   assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_W'(BUFFER_SIZE - 1))
      else $error("head pointer out of range");

   assert property (@(posedge clock) disable iff (reset)
      (take && q_word.kind == kbc_pkg::KIND_CLEAR) |=> (count_ff == '0 && head_ff == '0))
      else $error("clear did not empty the key buffer");

   assert property (@(posedge clock) disable iff (reset)
      (load && out_res_in.irq_raise) |-> irq_enable_ff)
      else $error("interrupt raised while disabled");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !out_valid_ff)
      else $error("pop result would overwrite a waiting word");

endmodule

@@ src/keyboard_buffer_controller_core.sv @@
`timescale 1ns / 1ps
// result: registered, on the result side in the cycle after a word is taken from the queue;
// a pop of a stored key first passes a registered key buffer read in the pop state
// throughput: one word per cycle while the result side has space and no key pop is pending
// reset: synchronous, clears queue, key count, head, pressed map and interrupt state at once;
// key buffer contents are left as they are

module keyboard_buffer_controller_core #(
   parameter int BUFFER_SIZE  = kbc_pkg::BUFFER_SIZE_DEFAULT,
   parameter int KEY_MAP_SIZE = kbc_pkg::KEY_MAP_SIZE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic        req_has_code,
   input  logic [7:0]  req_key_code,
   input  logic [15:0] req_command_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_c_valid,
   output logic [7:0]  rsp_c_value,
   output logic        rsp_irq_raise,
   output logic [15:0] rsp_irq_value
);

   kbc_pkg::action_type push_word;
   kbc_pkg::action_type pop_word;
   kbc_pkg::result_type rsp_word;
   logic                q_push, q_full, q_pop, q_empty;

   kbc_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_has_code  (req_has_code),
      .req_key_code  (req_key_code),
      .req_command_a (req_command_a),
      .req_operand_b (req_operand_b),
      .q_push        (q_push),
      .q_full        (q_full),
      .q_word        (push_word)
   );

   kbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .empty     (q_empty)
   );

   kbc_back #(
      .BUFFER_SIZE  (BUFFER_SIZE),
      .KEY_MAP_SIZE (KEY_MAP_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_word    (pop_word),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   assign rsp_c_valid   = rsp_word.c_valid;
   assign rsp_c_value   = rsp_word.c_value;
   assign rsp_irq_raise = rsp_word.irq_raise;
   assign rsp_irq_value = rsp_word.irq_value;

endmodule
